FILE: src/sorted_insert_table_macros.svh
// Assertion macros shared by the table RTL.
// Each macro takes a label, clock, active-low reset, the two sides of the
// property and a message.
`ifndef SORTED_INSERT_TABLE_MACROS_SVH
`define SORTED_INSERT_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/sit_pkg.sv
package sit_pkg;

    localparam int PRICE_W  = 32;
    localparam int AMOUNT_W = 32;
    localparam int TAG_W    = 16;
    localparam int INDEX_W  = 4;
    localparam int CNT_OW   = 5;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // one stored record
    typedef struct packed {
        logic [PRICE_W-1:0]  price;
        logic [AMOUNT_W-1:0] amount;
        logic [TAG_W-1:0]    tag;
    } t_entry;

    // per-cell control from the table controller
    typedef struct packed {
        logic ins;     // insert item this cycle
        logic beyond;  // cell index is at or past the fill count
    } t_cell_ctl;

endpackage

FILE: src/sit_cell.sv
// One slot of the sorted chain. Flags itself when the incoming record
// belongs at or before it, and on insert takes either the new record
// (first flagged cell) or its left neighbor's record (later cells).
module sit_cell (
    input  logic              i_clk,
    input  sit_pkg::t_cell_ctl i_ctl,
    input  sit_pkg::t_entry   i_new,
    input  sit_pkg::t_entry   i_prev,
    input  logic              i_prev_sel,
    output sit_pkg::t_entry   o_entry,
    output logic              o_sel
);
    import sit_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // stored key strictly smaller than the new key, or slot unused
    assign o_sel = i_ctl.beyond
                 || (r_entry.price < i_new.price)
                 || ((r_entry.price == i_new.price) && (r_entry.amount < i_new.amount));

    // load new record at the boundary, shift from the left past it
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_sel) begin
            n_entry = i_prev_sel ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: src/sorted_insert_table.sv
// Sorted record table: records are kept ordered by price, then amount,
// both descending, with equal keys in arrival order. For every command
// (insert, read, clear) busy never rises, so a new item may be started
// on every clock, and its result appears on the next cycle
// with o_done high for exactly that one cycle. The receiver cannot stall,
// so results must be captured when o_done is high. The rate is set by the
// row of slot cells, each of which compares its key with the incoming
// record and shifts toward the tail in the same cycle. Slots hold no reset
// value; reads only reach slots below the fill count.
`include "sorted_insert_table_macros.svh"

module sorted_insert_table #(
    parameter int CAPACITY = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_command,
    input  logic [sit_pkg::PRICE_W-1:0]    i_price,
    input  logic [sit_pkg::AMOUNT_W-1:0]   i_amount,
    input  logic [sit_pkg::TAG_W-1:0]      i_tag,
    input  logic [sit_pkg::INDEX_W-1:0]    i_index,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [sit_pkg::CNT_OW-1:0]     o_count,
    output logic [sit_pkg::INDEX_W-1:0]    o_position,
    output logic [sit_pkg::PRICE_W-1:0]    o_out_price,
    output logic [sit_pkg::AMOUNT_W-1:0]   o_out_amount,
    output logic [sit_pkg::TAG_W-1:0]      o_out_tag
);
    import sit_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = $clog2(CAPACITY);
    localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;

    logic          accept;
    logic          full;
    logic          do_ins;
    t_entry        new_rec;
    t_entry        cell_q   [CAPACITY];
    logic          cell_sel [CAPACITY];
    t_cell_ctl     cell_ctl [CAPACITY];
    logic [PW-1:0] ins_pos;
    t_entry        rd_entry;
    logic          rd_ok;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_done;
    logic [1:0]    r_status,   n_status;
    logic [CNT_OW-1:0]   r_ocount, n_ocount;
    logic [INDEX_W-1:0]  r_pos,    n_pos;
    t_entry        r_out,      n_out;

    logic [CW+CNT_OW-1:0]  cnt_wide;
    logic [PW+INDEX_W-1:0] pos_wide;
    logic [CW+INDEX_W-1:0] idx_wide;
    logic [CW+INDEX_W-1:0] cnt_cmp;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign full    = (r_count == CW'(CAPACITY));
    assign do_ins  = accept && (t_cmd'(i_command) == CMD_INSERT) && !full;
    assign new_rec = '{price: i_price, amount: i_amount, tag: i_tag};

    // slot chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign cell_ctl[g] = '{ins: do_ins, beyond: (r_count <= CW'(g))};
        if (g == 0) begin : g_head
            sit_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl[g]),
                .i_new      (new_rec),
                .i_prev     (new_rec),
                .i_prev_sel (1'b0),
                .o_entry    (cell_q[g]),
                .o_sel      (cell_sel[g])
            );
        end else begin : g_body
            sit_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl[g]),
                .i_new      (new_rec),
                .i_prev     (cell_q[g-1]),
                .i_prev_sel (cell_sel[g-1]),
                .o_entry    (cell_q[g]),
                .o_sel      (cell_sel[g])
            );
        end
    end

    // insert slot: the one cell where the flag first rises
    always_comb begin
        ins_pos = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (cell_sel[k] && ((k == 0) || !cell_sel[(k == 0) ? 0 : k - 1])) begin
                ins_pos = ins_pos | PW'(k);
            end
        end
    end

    // read mux over addressable slots
    always_comb begin
        rd_entry = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (i_index == INDEX_W'(k)) begin
                rd_entry = cell_q[k];
            end
        end
    end

    assign idx_wide = {{CW{1'b0}}, i_index};
    assign cnt_cmp  = {{INDEX_W{1'b0}}, r_count};
    assign rd_ok    = (idx_wide < cnt_cmp);
    assign pos_wide = {{INDEX_W{1'b0}}, ins_pos};
    assign cnt_wide = {{CNT_OW{1'b0}}, n_count};

    // result and count next values
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_pos    = '0;
        n_out    = '0;
        case (t_cmd'(i_command))
            CMD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    n_pos   = pos_wide[INDEX_W-1:0];
                end
            end
            CMD_READ: begin
                n_pos = i_index;
                if (rd_ok) begin
                    n_out = rd_entry;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_ocount = cnt_wide[CNT_OW-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_ocount <= n_ocount;
            r_pos    <= n_pos;
            r_out    <= n_out;
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_count      = r_ocount;
    assign o_position   = r_pos;
    assign o_out_price  = r_out.price;
    assign o_out_amount = r_out.amount;
    assign o_out_tag    = r_out.tag;

    // checks
    `SIT_ASSERT_NXT(a_done_follows, i_clk, i_rst_n, accept, o_done, "result missing after item")
    `SIT_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `SIT_ASSERT_NXT(a_ins_grows, i_clk, i_rst_n, do_ins, r_count == $past(r_count) + 1'b1, "insert did not grow count")
    `SIT_ASSERT_IMP(a_full_flag, i_clk, i_rst_n, o_done && (o_status == ST_FULL), r_count == CW'(CAPACITY), "full flag with room left")

endmodule
